FILE: rtl/core/adam_pkg.sv
// Shared constants, stage types and iteration steps for the Adam update pipeline
`default_nettype none
package adam_pkg;

  localparam int NUM_ELEMENTS = 4096;
  localparam int IDX_W        = $clog2(NUM_ELEMENTS);
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LR    = 3'd0,
    REG_BETA1 = 3'd1,
    REG_BETA2 = 3'd2,
    REG_EPS   = 3'd3
  } cfg_reg_t;

  localparam logic [31:0] LR_RST    = 32'd4294967;
  localparam logic [31:0] BETA1_RST = 32'd3865470566;
  localparam logic [31:0] BETA2_RST = 32'd4290672329;
  localparam logic [31:0] EPS_RST   = 32'd43;

  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [33:0] DELTA_CAP = 34'h2_0000_0000;

  localparam logic signed [35:0] RES_MAX = 36'sd2147483647;
  localparam logic signed [35:0] RES_MIN = -36'sd2147483648;

  // v * 2^64 / bc2 : 128 quotient bits, four per stage
  localparam int D1_STEPS = 4;
  localparam int D1_STG   = 128 / D1_STEPS;
  // integer square root of a 128-bit value: 64 root bits
  localparam int SQ_STEPS = 2;
  localparam int SQ_STG   = 64 / SQ_STEPS;
  // step quotient, only 35 bits are needed below the cap
  localparam int D2_STG   = 35;

  typedef struct packed {
    logic signed [31:0] p;
    logic signed [31:0] m;
    logic [32:0]        bc1;
    logic [32:0]        bc2;
    logic [127:0]       work;
    logic [31:0]        rem;
  } dv1_t;

  typedef struct packed {
    logic signed [31:0] p;
    logic signed [31:0] m;
    logic [32:0]        bc1;
    logic [127:0]       x;
    logic [64:0]        rem;
    logic [63:0]        root;
  } sq_t;

  typedef struct packed {
    logic signed [31:0] p;
    logic               pos;
    logic               ovf;
    logic [96:0]        den;
    logic [96:0]        rem;
    logic [D2_STG-1:0]  work;
  } dv2_t;

  // restoring division, numerator bits shift out the top of work,
  // quotient bits shift in at the bottom
  function automatic dv1_t dv1_step(input dv1_t s);
    dv1_t        r;
    logic [32:0] t;
    int          i;
    r = s;
    for (i = 0; i < D1_STEPS; i++) begin
      t = {r.rem, r.work[127]};
      if (t >= r.bc2) begin
        r.rem  = 32'(t - r.bc2);
        r.work = {r.work[126:0], 1'b1};
      end else begin
        r.rem  = t[31:0];
        r.work = {r.work[126:0], 1'b0};
      end
    end
    return r;
  endfunction

  // digit-by-digit square root, two radicand bits per root bit
  function automatic sq_t sq_step(input sq_t s);
    sq_t         r;
    logic [66:0] t;
    logic [66:0] trial;
    int          i;
    r = s;
    for (i = 0; i < SQ_STEPS; i++) begin
      t     = {r.rem, r.x[127:126]};
      trial = {1'b0, r.root, 2'b01};
      if (t >= trial) begin
        r.rem  = 65'(t - trial);
        r.root = {r.root[62:0], 1'b1};
      end else begin
        r.rem  = t[64:0];
        r.root = {r.root[62:0], 1'b0};
      end
      r.x = {r.x[125:0], 2'b00};
    end
    return r;
  endfunction

  function automatic dv2_t dv2_step(input dv2_t s);
    dv2_t        r;
    logic [97:0] t;
    r = s;
    t = {r.rem, r.work[D2_STG-1]};
    if (t >= {1'b0, r.den}) begin
      r.rem  = 97'(t - {1'b0, r.den});
      r.work = {r.work[D2_STG-2:0], 1'b1};
    end else begin
      r.rem  = t[96:0];
      r.work = {r.work[D2_STG-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/adam_update.sv
// Adam optimiser element update: moment stores, bias correction and step pipeline
//
// Items come in on item_valid/item_stall with element_index, gradient, param_value
// and new_step; each gives one result on result_valid/result_stall (new_param and
// saturated). An item is taken when valid is high and stall is low.
// Configuration: cfg_write with cfg_index and cfg_data writes learning_rate (0),
// beta_first (1), beta_second (2) or epsilon (3); other indexes are ignored.
// One item per cycle is sustained unless a stall holds the input; the moment
// read-modify-write spans the first three stages, so an item whose index
// matches one of those in-flight items waits until the earlier one has
// written its moments back.
// After reset both moment stores are zeroed by a pass over all 4096 entries, one entry
// a cycle, with item_stall held high; configuration writes are taken meanwhile.
// Reset also sets the bias-correction powers to one and the registers to defaults.
// When result_stall is high with a result waiting, the whole pipeline holds and
// item_stall rises; nothing is dropped or repeated.
`default_nettype none
module adam_update import adam_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [11:0]          element_index,
  input  logic signed [31:0]   gradient,
  input  logic signed [31:0]   param_value,
  input  logic                 new_step,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic signed [31:0]   new_param,
  output logic                 saturated
);

  logic [31:0] learning_rate, beta_first, beta_second, epsilon;
  logic [32:0] beta1_power, beta2_power;

  logic             en, accept, hz;
  logic             clr_busy;
  logic [IDX_W-1:0] clr_addr;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RST;
      beta_first    <= BETA1_RST;
      beta_second   <= BETA2_RST;
      epsilon       <= EPS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LR:    learning_rate <= cfg_data;
        REG_BETA1: beta_first    <= cfg_data;
        REG_BETA2: beta_second   <= cfg_data;
        REG_EPS:   epsilon       <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic             v1, v2, v3, v4;
  logic [IDX_W-1:0] idx1, idx2, idx3;

  assign en     = ~(result_valid & result_stall);
  assign hz     = (v1 & (idx1 == element_index[IDX_W-1:0]))
                | (v2 & (idx2 == element_index[IDX_W-1:0]))
                | (v3 & (idx3 == element_index[IDX_W-1:0]));
  assign item_stall = clr_busy | ~en | hz;
  assign accept     = item_valid & ~item_stall;

  // ---------------- bias correction powers ----------------
  logic [64:0] pw1_prod, pw2_prod;
  logic [32:0] pw1_cur, pw2_cur;

  assign pw1_prod = 65'(beta1_power) * 65'(beta_first) + 65'h0_8000_0000;
  assign pw2_prod = 65'(beta2_power) * 65'(beta_second) + 65'h0_8000_0000;
  assign pw1_cur  = new_step ? pw1_prod[64:32] : beta1_power;
  assign pw2_cur  = new_step ? pw2_prod[64:32] : beta2_power;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta1_power <= ONE_Q32;
      beta2_power <= ONE_Q32;
    end else if (accept) begin
      beta1_power <= pw1_cur;
      beta2_power <= pw2_cur;
    end
  end

  // ---------------- clearing pass ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(NUM_ELEMENTS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ---------------- moment stores ----------------
  logic signed [31:0] mem_m [NUM_ELEMENTS];
  logic [63:0]        mem_v [NUM_ELEMENTS];
  logic signed [31:0] rdm;
  logic [63:0]        rdv;
  logic               wm_en, wv_en;
  logic [IDX_W-1:0]   wm_addr, wv_addr;
  logic signed [31:0] wm_data, m_new;
  logic [63:0]        wv_data, v_new;

  assign wm_en   = clr_busy | (en & v2);
  assign wm_addr = clr_busy ? clr_addr : idx2;
  assign wm_data = clr_busy ? '0 : m_new;
  assign wv_en   = clr_busy | (en & v3);
  assign wv_addr = clr_busy ? clr_addr : idx3;
  assign wv_data = clr_busy ? '0 : v_new;

  always_ff @(posedge clk) begin
    if (wm_en) begin
      mem_m[wm_addr] <= wm_data;
    end
    if (en) begin
      rdm <= mem_m[element_index[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wv_en) begin
      mem_v[wv_addr] <= wv_data;
    end
    if (en) begin
      rdv <= mem_v[element_index[IDX_W-1:0]];
    end
  end

  // ---------------- stage 1: item, store read ----------------
  logic signed [31:0] g1, p1;
  logic [32:0]        pw1_1, pw2_1;

  always_ff @(posedge clk) begin
    if (en) begin
      idx1  <= element_index[IDX_W-1:0];
      g1    <= gradient;
      p1    <= param_value;
      pw1_1 <= pw1_cur;
      pw2_1 <= pw2_cur;
    end
  end

  // ---------------- stage 2: moment products ----------------
  logic [32:0]        ob1, ob2, bc1_c, bc2_c;
  logic signed [64:0] pm1_c, pm2_c;
  logic signed [63:0] gsq_c;
  logic [63:0]        pvl_c, pvh_c;

  assign ob1   = ONE_Q32 - {1'b0, beta_first};
  assign ob2   = ONE_Q32 - {1'b0, beta_second};
  assign pm1_c = 65'(rdm) * 65'($signed({1'b0, beta_first}));
  assign pm2_c = 65'(g1) * 65'($signed({1'b0, ob1}));
  assign gsq_c = 64'(g1) * 64'(g1);
  assign pvl_c = 64'(rdv[31:0]) * 64'(beta_second);
  assign pvh_c = 64'(rdv[63:32]) * 64'(beta_second);

  always_comb begin
    bc1_c = ONE_Q32 - pw1_1;
    bc2_c = ONE_Q32 - pw2_1;
    if (bc1_c == '0) bc1_c = 33'd1;
    if (bc2_c == '0) bc2_c = 33'd1;
  end

  logic signed [31:0] p2;
  logic signed [64:0] pm1_2, pm2_2;
  logic [63:0]        g2_2, pvl_2, pvh_2;
  logic [32:0]        bc1_2, bc2_2;

  always_ff @(posedge clk) begin
    if (en) begin
      idx2  <= idx1;
      p2    <= p1;
      pm1_2 <= pm1_c;
      pm2_2 <= pm2_c;
      g2_2  <= gsq_c;
      pvl_2 <= pvl_c;
      pvh_2 <= pvh_c;
      bc1_2 <= bc1_c;
      bc2_2 <= bc2_c;
    end
  end

  // ---------------- stage 3: first moment, second moment products ----------------
  logic signed [65:0] msum_c;
  logic [95:0]        pv_c;
  logic [64:0]        pgl_c, pgh_c;

  assign msum_c = 66'(pm1_2) + 66'(pm2_2) + 66'sd2147483648;
  assign m_new  = msum_c[63:32];
  assign pv_c   = {pvh_2, 32'b0} + 96'(pvl_2);
  assign pgl_c  = 65'(g2_2[31:0]) * 65'(ob2);
  assign pgh_c  = 65'(g2_2[63:32]) * 65'(ob2);

  logic signed [31:0] p3, m3;
  logic [95:0]        pv_3;
  logic [64:0]        pgl_3, pgh_3;
  logic [32:0]        bc1_3, bc2_3;

  always_ff @(posedge clk) begin
    if (en) begin
      idx3  <= idx2;
      p3    <= p2;
      m3    <= m_new;
      pv_3  <= pv_c;
      pgl_3 <= pgl_c;
      pgh_3 <= pgh_c;
      bc1_3 <= bc1_2;
      bc2_3 <= bc2_2;
    end
  end

  // ---------------- stage 4: second moment ----------------
  logic [96:0] vsum_c;

  assign vsum_c = 97'(pv_3) + {pgh_3, 32'b0} + 97'(pgl_3) + 97'h0_8000_0000;
  assign v_new  = vsum_c[95:32];

  logic signed [31:0] p4, m4;
  logic [63:0]        vv4;
  logic [32:0]        bc1_4, bc2_4;

  always_ff @(posedge clk) begin
    if (en) begin
      p4    <= p3;
      m4    <= m3;
      vv4   <= v_new;
      bc1_4 <= bc1_3;
      bc2_4 <= bc2_3;
    end
  end

  // ---------------- v / bc2 in Q.64, then its square root ----------------
  dv1_t d1_src;
  dv1_t d1 [D1_STG];
  sq_t  sq_src;
  sq_t  sq [SQ_STG];

  always_comb begin
    d1_src.p    = p4;
    d1_src.m    = m4;
    d1_src.bc1  = bc1_4;
    d1_src.bc2  = bc2_4;
    d1_src.work = {vv4, 64'b0};
    d1_src.rem  = '0;
  end

  always_comb begin
    sq_src.p    = d1[D1_STG-1].p;
    sq_src.m    = d1[D1_STG-1].m;
    sq_src.bc1  = d1[D1_STG-1].bc1;
    sq_src.x    = d1[D1_STG-1].work;
    sq_src.rem  = '0;
    sq_src.root = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= dv1_step(d1_src);
      for (int k = 1; k < D1_STG; k++) d1[k] <= dv1_step(d1[k-1]);
      sq[0] <= sq_step(sq_src);
      for (int k = 1; k < SQ_STG; k++) sq[k] <= sq_step(sq[k-1]);
    end
  end

  // ---------------- denominator and numerator ----------------
  logic [64:0]        dsum_c;
  logic [63:0]        dd_c;
  logic signed [31:0] pa_p, pa_m;
  logic [32:0]        pa_bc1;
  logic [63:0]        pa_d;

  always_comb begin
    dsum_c = 65'(sq[SQ_STG-1].root) + 65'(epsilon);
    dd_c   = dsum_c[64] ? '1 : dsum_c[63:0];
    if (dd_c == '0) dd_c = 64'd1;
  end

  logic [31:0] mag_c;
  assign mag_c = pa_m[31] ? 32'(~pa_m + 32'sd1) : 32'(pa_m);

  logic signed [31:0] pb_p;
  logic               pb_pos;
  logic [64:0]        pb_dl, pb_dh;
  logic [63:0]        pb_num;

  logic signed [31:0] pc_p;
  logic               pc_pos;
  logic [96:0]        pc_den;
  logic [63:0]        pc_num;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_p   <= sq[SQ_STG-1].p;
      pa_m   <= sq[SQ_STG-1].m;
      pa_bc1 <= sq[SQ_STG-1].bc1;
      pa_d   <= dd_c;

      pb_p   <= pa_p;
      pb_pos <= ~pa_m[31] & (pa_m != '0);
      pb_dl  <= 65'(pa_bc1) * 65'(pa_d[31:0]);
      pb_dh  <= 65'(pa_bc1) * 65'(pa_d[63:32]);
      pb_num <= 64'(learning_rate) * 64'(mag_c);

      pc_p   <= pb_p;
      pc_pos <= pb_pos;
      pc_den <= {pb_dh, 32'b0} + 97'(pb_dl);
      pc_num <= pb_num;
    end
  end

  // ---------------- step division, capped ----------------
  dv2_t d2_src, d2_in;
  dv2_t d2 [D2_STG];

  always_comb begin
    d2_src.p    = pc_p;
    d2_src.pos  = pc_pos;
    d2_src.den  = pc_den;
    d2_src.rem  = 97'(pc_num[63:3]);
    // quotient at or above 2^35 is capped anyway
    d2_src.ovf  = 97'(pc_num[63:3]) >= pc_den;
    d2_src.work = {pc_num[2:0], 32'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_in <= d2_src;
      d2[0] <= dv2_step(d2_in);
      for (int k = 1; k < D2_STG; k++) d2[k] <= dv2_step(d2[k-1]);
    end
  end

  // ---------------- rounding and cap ----------------
  logic        rnd_c;
  logic [35:0] q_c;
  logic [33:0] delta_c;

  assign rnd_c   = {d2[D2_STG-1].rem, 1'b0} >= {1'b0, d2[D2_STG-1].den};
  assign q_c     = 36'(d2[D2_STG-1].work) + 36'(rnd_c);
  assign delta_c = (d2[D2_STG-1].ovf || q_c > 36'(DELTA_CAP)) ? DELTA_CAP : q_c[33:0];

  logic signed [31:0] pr_p;
  logic               pr_pos;
  logic [33:0]        pr_delta;

  always_ff @(posedge clk) begin
    if (en) begin
      pr_p     <= d2[D2_STG-1].p;
      pr_pos   <= d2[D2_STG-1].pos;
      pr_delta <= delta_c;
    end
  end

  // ---------------- result ----------------
  logic signed [35:0] res_c, px_c, dx_c;
  logic signed [31:0] np_c;
  logic               sat_c;

  always_comb begin
    px_c  = 36'(pr_p);
    dx_c  = $signed({2'b00, pr_delta});
    res_c = pr_pos ? px_c - dx_c : px_c + dx_c;
    sat_c = 1'b0;
    np_c  = res_c[31:0];
    if (res_c > RES_MAX) begin
      np_c  = RES_MAX[31:0];
      sat_c = 1'b1;
    end else if (res_c < RES_MIN) begin
      np_c  = RES_MIN[31:0];
      sat_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_param <= np_c;
      saturated <= sat_c;
    end
  end

  // ---------------- valid bits ----------------
  logic [D1_STG-1:0] d1_vld;
  logic [SQ_STG-1:0] sq_vld;
  logic [D2_STG-1:0] d2_vld;
  logic              pa_vld, pb_vld, pc_vld, d2in_vld, pr_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      d1_vld       <= '0;
      sq_vld       <= '0;
      pa_vld       <= 1'b0;
      pb_vld       <= 1'b0;
      pc_vld       <= 1'b0;
      d2in_vld     <= 1'b0;
      d2_vld       <= '0;
      pr_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1           <= accept;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      d1_vld       <= {d1_vld[D1_STG-2:0], v4};
      sq_vld       <= {sq_vld[SQ_STG-2:0], d1_vld[D1_STG-1]};
      pa_vld       <= sq_vld[SQ_STG-1];
      pb_vld       <= pa_vld;
      pc_vld       <= pb_vld;
      d2in_vld     <= pc_vld;
      d2_vld       <= {d2_vld[D2_STG-2:0], d2in_vld};
      pr_vld       <= d2_vld[D2_STG-1];
      result_valid <= pr_vld;
    end
  end

  // ---------------- assertions ----------------
  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !accept)
    else $error("item taken during store clearing");

  a_front_indexes_distinct: assert property (@(posedge clk) disable iff (rst)
    !((v1 && v2 && idx1 == idx2) || (v1 && v3 && idx1 == idx3) ||
      (v2 && v3 && idx2 == idx3)))
    else $error("two items on one index inside the moment update window");

  a_powers_bounded: assert property (@(posedge clk) disable iff (rst)
    beta1_power <= ONE_Q32 && beta2_power <= ONE_Q32)
    else $error("bias correction power above one");

  a_clear_wraps: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_busy) |-> clr_addr == '0)
    else $error("clearing pass ended before covering every entry");

endmodule
`default_nettype wire

FILE: sim/adam_update_checker.sv
// Checker for adam_update: follows the config port, predicts each result and compares
module adam_update_checker import adam_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  logic [11:0]          element_index,
  input  logic signed [31:0]   gradient,
  input  logic signed [31:0]   param_value,
  input  logic                 new_step,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  logic signed [31:0]   new_param,
  input  logic                 saturated,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } update_t;

  update_t            want_q[$];
  logic signed [31:0] mom1 [NUM_ELEMENTS];
  logic [63:0]        mom2 [NUM_ELEMENTS];
  logic [32:0]        pow1, pow2;
  logic [31:0]        lr, beta1, beta2, eps;

  function automatic logic [63:0] root128(input logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (x >= 128'(c) * 128'(c)) r = c;
    end
    return r;
  endfunction

  task automatic adam_predict(input logic [11:0] idx, input logic signed [31:0] g,
                              input logic signed [31:0] p, input logic ns);
    logic signed [71:0] mo, ga, w1, w2, acc;
    logic signed [63:0] gs;
    logic [127:0]       vacc, quo, numer, den, dq, dr;
    logic [63:0]        g2, s, d, mag, vn;
    logic [64:0]        dsum;
    logic [32:0]        bc1, bc2;
    logic [35:0]        delta;
    logic signed [35:0] res;
    logic signed [31:0] mn;
    update_t            u;
    if (ns) begin
      pow1 = 33'((66'(pow1) * 66'(beta1) + 66'd2147483648) >> 32);
      pow2 = 33'((66'(pow2) * 66'(beta2) + 66'd2147483648) >> 32);
    end
    mo  = mom1[idx];
    ga  = g;
    w1  = $signed({40'd0, beta1});
    w2  = $signed(72'(ONE_Q32 - 33'(beta1)));
    acc = mo * w1 + ga * w2 + 72'sd2147483648;
    mn  = 32'(acc >>> 32);
    mom1[idx] = mn;
    gs   = g;
    g2   = 64'(gs * gs);
    vacc = 128'(mom2[idx]) * 128'(beta2) + 128'(g2) * 128'(ONE_Q32 - 33'(beta2))
         + 128'd2147483648;
    vn   = vacc[95:32];
    mom2[idx] = vn;
    bc1 = ONE_Q32 - pow1;
    bc2 = ONE_Q32 - pow2;
    if (bc1 == 0) bc1 = 33'd1;
    if (bc2 == 0) bc2 = 33'd1;
    quo  = {vn, 64'd0} / 128'(bc2);
    s    = root128(quo);
    dsum = 65'(s) + 65'(eps);
    d    = dsum[64] ? '1 : dsum[63:0];
    if (d == 0) d = 64'd1;
    mag   = mn < 0 ? 64'(-64'(mn)) : 64'(mn);
    numer = (128'(lr) * 128'(mag)) << 32;
    den   = 128'(bc1) * 128'(d);
    dq    = numer / den;
    dr    = numer % den;
    if (dr >= den - dr) dq = dq + 1;
    delta = (dq > 128'(DELTA_CAP)) ? 36'(DELTA_CAP) : 36'(dq);
    res   = (mn > 0) ? 36'(p) - $signed(delta) : 36'(p) + $signed(delta);
    u.sat = 1'b0;
    if (res > RES_MAX) begin
      res = RES_MAX;
      u.sat = 1'b1;
    end
    if (res < RES_MIN) begin
      res = RES_MIN;
      u.sat = 1'b1;
    end
    u.value = 32'(res);
    want_q = {want_q, u};
  endtask

  always @(posedge clk) begin
    update_t w;
    if (rst) begin
      for (int i = 0; i < NUM_ELEMENTS; i++) begin
        mom1[i] = '0;
        mom2[i] = '0;
      end
      pow1 = ONE_Q32;
      pow2 = ONE_Q32;
      lr = LR_RST;
      beta1 = BETA1_RST;
      beta2 = BETA2_RST;
      eps = EPS_RST;
      want_q.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LR:    lr = cfg_data;
          REG_BETA1: beta1 = cfg_data;
          REG_BETA2: beta2 = cfg_data;
          REG_EPS:   eps = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result new_param=%h saturated=%b",
                   $time, new_param, saturated);
          errors++;
        end else begin
          w = want_q.pop_front();
          if (new_param !== w.value) begin
            $display("%0t: new_param expected %h actual %h", $time, w.value, new_param);
            errors++;
          end
          if (saturated !== w.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, w.sat, saturated);
            errors++;
          end
        end
      end
      if (item_valid && !item_stall)
        adam_predict(element_index, gradient, param_value, new_step);
    end
    pending = want_q.size();
  end

endmodule

FILE: sim/tb_adam_update.sv
// Testbench top for adam_update: stimulus, receiver stalls, timeout and verdict
module tb_adam_update import adam_pkg::*; ();

  localparam int LIMIT = 800000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 item_valid;
  logic                 item_stall;
  logic [11:0]          element_index;
  logic signed [31:0]   gradient;
  logic signed [31:0]   param_value;
  logic                 new_step;
  logic                 result_valid;
  logic                 result_stall;
  logic signed [31:0]   new_param;
  logic                 saturated;
  int                   errors, pending, cycles, burst_left;
  logic                 hold_go, hold_done;

  adam_update u_dut (.*);
  adam_update_checker u_chk (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
    end
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: stall pattern changes every so often, one long hold on request
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    result_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        result_stall <= 1'b1;
        repeat (400) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= (left % 2 == 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic [11:0] idx, input logic [31:0] g,
                           input logic [31:0] p, input logic ns);
    element_index <= idx;
    gradient <= g;
    param_value <= p;
    new_step <= ns;
    item_valid <= 1'b1;
    do @(negedge clk); while (item_stall);
    @(posedge clk);
  endtask

  task automatic maybe_gap(input logic no_gaps);
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 30);
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (130) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] lr, input logic [31:0] b1,
                            input logic [31:0] b2, input logic [31:0] ep);
    logic [31:0] vals [4];
    vals = '{lr, b1, b2, ep};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    // indexes beyond the register list must be ignored
    cfg_index <= CFG_IDX_W'($urandom_range(4, 7));
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 2047)) - 1024);
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  task automatic random_phase(input int n, input logic start_hold);
    logic [11:0] idx;
    for (int k = 0; k < n; k++) begin
      if (start_hold && k == 5) hold_go = 1'b1;
      idx = $urandom_range(0, 4) < 3 ? 12'($urandom_range(0, 15)) : 12'($urandom);
      send_item(idx, pick_value(), pick_value(), $urandom_range(0, 9) == 0);
      if (k != n - 1) maybe_gap(start_hold && k < 300);
    end
    drain();
  endtask

  initial begin
    clk = 0;
    rst = 1;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 0;
    element_index = '0;
    gradient = '0;
    param_value = '0;
    new_step = 0;
    burst_left = 0;
    hold_go = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults; the first items come before any step, so both bias corrections are zero
    send_item(12'd0, 32'd0, 32'd0, 1'b0);
    send_item(12'd1, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_item(12'd2, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(12'd4095, 32'hffff_ffff, 32'd0, 1'b1);
    send_item(12'd4095, 32'h0001_0000, 32'h7fff_ffff, 1'b0);
    send_item(12'd1, 32'h8000_0000, 32'h7fff_0000, 1'b1);
    send_item(12'd2, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_item(12'd3, 32'h0000_0001, 32'h1234_5678, 1'b1);
    drain();
    // huge step and zero denominator
    set_config(32'hffff_ffff, 32'd0, 32'd0, 32'd0);
    send_item(12'd100, 32'd0, 32'd0, 1'b0);
    send_item(12'd101, 32'd1, 32'h8000_0000, 1'b1);
    send_item(12'd102, 32'hffff_ffff, 32'h7fff_ffff, 1'b0);
    send_item(12'd103, 32'h7fff_ffff, 32'd0, 1'b1);
    send_item(12'd100, 32'h8000_0000, 32'd5, 1'b0);
    drain();
    // zero learning rate, slowest decay
    set_config(32'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(12'd200, 32'h7fff_ffff, 32'h0bad_cafe, 1'b1);
    send_item(12'd200, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(12'd201, 32'h0002_0000, 32'h7fff_ffff, 1'b1);
    drain();

    set_config(LR_RST, BETA1_RST, BETA2_RST, EPS_RST);
    random_phase(300, 1'b1);
    set_config($urandom, $urandom, $urandom, $urandom);
    random_phase(110, 1'b0);
    set_config(32'd1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    random_phase(100, 1'b0);
    set_config(32'hffff_ffff, 32'd0, 32'd0, 32'd1);
    random_phase(100, 1'b0);
    set_config($urandom | 32'h0100_0000, $urandom_range(32'h8000_0000, 32'hffff_ffff),
               $urandom_range(32'hf000_0000, 32'hffff_ffff), $urandom_range(1, 1000));
    random_phase(120, 1'b0);
    set_config($urandom, $urandom, $urandom, 32'd0);
    random_phase(100, 1'b0);

    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
